### hw/rtl/ldcc_pkg.sv
`default_nettype none

package ldcc_pkg;

    // Top of the automatic triangle fade, in percent.
    localparam logic [6:0] FADE_TOP = 7'd100;

    // Division of period * level by 100 is done as a multiply by a
    // rounded-up reciprocal and a shift. It is exact for every product
    // below 2^23, which covers a 16-bit period times a 7-bit level.
    localparam int          PROD_W      = 23;
    localparam int          RECIP_SHIFT = 30;
    localparam int          RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int          QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;

    // Characters used by the command parser.
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_A      = "a";
    localparam logic [7:0] CH_U      = "u";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_O      = "o";
    localparam logic [7:0] CH_M      = "m";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_L      = "l";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";

    // Item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // What an item does to the compare value.
    localparam logic [1:0] ACT_KEEP = 2'd0;
    localparam logic [1:0] ACT_ZERO = 2'd1;
    localparam logic [1:0] ACT_LOAD = 2'd2;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] rx_byte;
    } ldcc_in_t;

    typedef struct packed {
        logic [15:0] duty_compare;
        logic        auto_mode;
        logic [6:0]  led_level;
    } ldcc_out_t;

endpackage

`default_nettype wire

### hw/rtl/led_dimmer_command_controller_top.sv
`default_nettype none

// LED dimmer command controller. Each input word is either a received serial
// byte or a 10 ms tick, and each one produces exactly one output word with the
// PWM compare value, the mode and the current brightness percentage. Bytes
// drive a parser for '$'-framed commands: "$manual$" in auto mode, "$auto$"
// and "$xxxNN$" in manual mode. Ticks step the auto triangle fade or move the
// manual ramp one step toward its target. The block takes one word per clock
// cycle while in_stall is low. Each word passes through four registers: the
// input register, the parser and level update stage, the period-times-level
// multiplier stage, and the output register, which the divide-by-100
// reciprocal multiplier loads. A stalled output holds the pipeline, and the
// input stalls once all four registers are full. The user must write the
// timer_period register through cfg_write and cfg_data only while no word is
// in flight; the block itself does not enforce this.
module led_dimmer_command_controller_top
    import ldcc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_write,
    input  wire logic [15:0] cfg_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire ldcc_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output ldcc_out_t      out_data
);

    // Configuration register.
    logic [15:0] timer_period_reg;

    // Pipeline registers.
    logic               s1_valid_reg;
    ldcc_in_t           s1_word_reg;
    logic               s2_valid_reg;
    logic               s2_auto_reg;
    logic [6:0]         s2_level_reg;
    logic [1:0]         s2_act_reg;
    logic               s3_valid_reg;
    logic               s3_auto_reg;
    logic [6:0]         s3_level_reg;
    logic [1:0]         s3_act_reg;
    logic [PROD_W-1:0]  s3_prod_reg;
    logic               out_valid_reg;
    ldcc_out_t          out_reg;
    logic [15:0]        compare_reg;

    // Controller state.
    logic       mode_auto_reg,     mode_auto_next;
    logic       frame_open_reg,    frame_open_next;
    logic [2:0] frame_pos_reg,     frame_pos_next;
    logic [7:0] cmd_buf_reg [6];
    logic [7:0] cmd_buf_next [6];
    logic [6:0] target_reg,        target_next;
    logic       restart_reg,       restart_next;
    logic [6:0] ramp_reg,          ramp_next;
    logic       fade_falling_reg,  fade_falling_next;
    logic [6:0] fade_reg,          fade_next;
    logic [1:0] act_next;

    logic adv2, adv3, adv4, in_accept;

    logic [PROD_W-1:0]               prod_next;
    logic [PROD_W+RECIP_W-1:0]       scaled;
    logic [QUOT_W-1:0]               quot;
    logic [15:0]                     duty;
    logic [15:0]                     compare_next;

    // Stage advance: a stage moves when the next one is empty or moving.
    assign adv4      = s3_valid_reg && (!out_valid_reg || !out_stall);
    assign adv3      = s2_valid_reg && (!s3_valid_reg || adv4);
    assign adv2      = s1_valid_reg && (!s2_valid_reg || adv3);
    assign in_stall  = s1_valid_reg && s2_valid_reg && !adv3;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Parser and level update for the word in the input register.
    always_comb
    begin
        logic [7:0] b;
        logic [6:0] v;
        logic       buf_write;
        mode_auto_next    = mode_auto_reg;
        frame_open_next   = frame_open_reg;
        frame_pos_next    = frame_pos_reg;
        target_next       = target_reg;
        restart_next      = restart_reg;
        ramp_next         = ramp_reg;
        fade_falling_next = fade_falling_reg;
        fade_next         = fade_reg;
        act_next          = ACT_KEEP;
        buf_write         = 1'b0;
        v                 = 7'd0;
        b                 = s1_word_reg.rx_byte;
        for (int i = 0; i < 6; i++)
        begin
            cmd_buf_next[i] = cmd_buf_reg[i];
        end

        if (s1_word_reg.item_kind == KIND_BYTE)
        begin
            if (mode_auto_reg)
            begin
                if (b == CH_DOLLAR && !frame_open_reg)
                begin
                    frame_open_next = 1'b1;
                end
                else if (frame_open_reg && frame_pos_reg < 3'd6)
                begin
                    buf_write = 1'b1;
                end
                else if (frame_open_reg && b == CH_DOLLAR
                         && cmd_buf_reg[0] == CH_M && cmd_buf_reg[1] == CH_A
                         && cmd_buf_reg[2] == CH_N && cmd_buf_reg[3] == CH_U
                         && cmd_buf_reg[4] == CH_A && cmd_buf_reg[5] == CH_L)
                begin
                    frame_open_next = 1'b0;
                    frame_pos_next  = 3'd0;
                    mode_auto_next  = 1'b0;
                    restart_next    = 1'b1;
                end
                else if (frame_open_reg)
                begin
                    frame_open_next = 1'b0;
                    frame_pos_next  = 3'd0;
                end
            end
            else
            begin
                if (b == CH_DOLLAR && !frame_open_reg)
                begin
                    frame_open_next = 1'b1;
                end
                else if (frame_open_reg && frame_pos_reg < 3'd5)
                begin
                    buf_write = 1'b1;
                end
                else if (frame_open_reg && frame_pos_reg == 3'd5 && b == CH_DOLLAR)
                begin
                    frame_open_next = 1'b0;
                    frame_pos_next  = 3'd0;
                    if (cmd_buf_reg[3] inside {[CH_ZERO:CH_NINE]})
                    begin
                        v = 7'(cmd_buf_reg[3] - CH_ZERO);
                        if (cmd_buf_reg[4] inside {[CH_ZERO:CH_NINE]})
                        begin
                            v = 7'(v * 7'd10 + 7'(cmd_buf_reg[4] - CH_ZERO));
                        end
                        target_next = v;
                    end
                end
                else if (frame_open_reg)
                begin
                    frame_open_next = 1'b0;
                    frame_pos_next  = 3'd0;
                end
            end

            // Store the byte at the current frame position.
            if (buf_write)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    if (frame_pos_reg == 3'(i))
                    begin
                        cmd_buf_next[i] = b;
                    end
                end
                frame_pos_next = 3'(frame_pos_reg + 3'd1);
            end

            // In manual mode an open frame holding "auto$" returns to auto.
            if (!mode_auto_reg && frame_open_next
                && cmd_buf_next[0] == CH_A && cmd_buf_next[1] == CH_U
                && cmd_buf_next[2] == CH_T && cmd_buf_next[3] == CH_O
                && cmd_buf_next[4] == CH_DOLLAR)
            begin
                mode_auto_next  = 1'b1;
                frame_open_next = 1'b0;
                frame_pos_next  = 3'd0;
            end
        end
        else if (!mode_auto_reg)
        begin
            // Manual tick: optional restart, then one step toward the target.
            if (restart_reg)
            begin
                ramp_next    = 7'd0;
                restart_next = 1'b0;
                act_next     = ACT_ZERO;
            end
            if (ramp_next < target_reg)
            begin
                ramp_next = 7'(ramp_next + 7'd1);
                act_next  = ACT_LOAD;
            end
            else if (ramp_next > target_reg)
            begin
                ramp_next = 7'(ramp_next - 7'd1);
                act_next  = ACT_LOAD;
            end
        end
        else
        begin
            // Auto tick: turn at the ends, then step the fade.
            if (!fade_falling_reg && fade_reg == FADE_TOP)
            begin
                fade_falling_next = 1'b1;
            end
            else if (fade_falling_reg && fade_reg == 7'd0)
            begin
                fade_falling_next = 1'b0;
            end
            if (!fade_falling_next)
            begin
                fade_next = 7'(fade_reg + 7'd1);
            end
            else
            begin
                fade_next = 7'(fade_reg - 7'd1);
            end
            act_next = ACT_LOAD;
        end
    end

    // Compare value arithmetic.
    assign prod_next = PROD_W'(timer_period_reg) * PROD_W'(s2_level_reg);
    assign scaled    = (PROD_W+RECIP_W)'(s3_prod_reg) * (PROD_W+RECIP_W)'(RECIP_100);
    assign quot      = scaled[PROD_W+RECIP_W-1:RECIP_SHIFT];
    assign duty      = (quot > QUOT_W'(16'hFFFF)) ? 16'hFFFF : quot[15:0];

    always_comb
    begin
        case (s3_act_reg)
            ACT_ZERO: compare_next = 16'd0;
            ACT_LOAD: compare_next = duty;
            default:  compare_next = compare_reg;
        endcase
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_period_reg <= 16'd99;
        end
        else if (cfg_write)
        begin
            timer_period_reg <= cfg_data;
        end
    end

    // Controller state, updated as a word leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_auto_reg    <= 1'b1;
            frame_open_reg   <= 1'b0;
            frame_pos_reg    <= 3'd0;
            target_reg       <= 7'd0;
            restart_reg      <= 1'b0;
            ramp_reg         <= 7'd0;
            fade_falling_reg <= 1'b0;
            fade_reg         <= 7'd0;
            for (int i = 0; i < 6; i++)
            begin
                cmd_buf_reg[i] <= 8'd0;
            end
        end
        else if (adv2)
        begin
            mode_auto_reg    <= mode_auto_next;
            frame_open_reg   <= frame_open_next;
            frame_pos_reg    <= frame_pos_next;
            target_reg       <= target_next;
            restart_reg      <= restart_next;
            ramp_reg         <= ramp_next;
            fade_falling_reg <= fade_falling_next;
            fade_reg         <= fade_next;
            for (int i = 0; i < 6; i++)
            begin
                cmd_buf_reg[i] <= cmd_buf_next[i];
            end
        end
    end

    // Pipeline valid bits and the compare value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            compare_reg   <= 16'd0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv2)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (adv2)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (adv3)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (adv3)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (adv4)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (adv4)
            begin
                out_valid_reg <= 1'b1;
                compare_reg   <= compare_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_word_reg <= in_data;
        end
        if (adv2)
        begin
            s2_auto_reg  <= mode_auto_next;
            s2_level_reg <= mode_auto_next ? fade_next : ramp_next;
            s2_act_reg   <= act_next;
        end
        if (adv3)
        begin
            s3_auto_reg  <= s2_auto_reg;
            s3_level_reg <= s2_level_reg;
            s3_act_reg   <= s2_act_reg;
            s3_prod_reg  <= prod_next;
        end
        if (adv4)
        begin
            out_reg.duty_compare <= compare_next;
            out_reg.auto_mode    <= s3_auto_reg;
            out_reg.led_level    <= s3_level_reg;
        end
    end

endmodule

`default_nettype wire
